// ===== rtl/nrwm_pkg.sv =====
// shared types and constants for the translation rule table
`timescale 1ns / 1ps

package nrwm_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic [1:0] KIND_EXACT         = 2'd0;
  localparam logic [1:0] KIND_ADDR_ANY_PORT = 2'd1;
  localparam logic [1:0] KIND_ANY_ADDR_PORT = 2'd2;
  localparam logic [1:0] KIND_NONE          = 2'd3;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // transaction token walking down the cell row
  typedef struct packed {
    logic        vld;
    logic        lookup;
    logic [1:0]  kind;      // normalised key kind (insert only)
    logic [31:0] ip;        // normalised key address
    logic [15:0] port;      // normalised key port
    logic [31:0] tgt_ip;    // insert: new target, lookup: best target so far
    logic [15:0] tgt_port;
    logic [1:0]  best;      // lookup: best kind found so far
    logic        found;     // insert: key placed or overwritten, or invalid kind dropped
  } tok_t;

endpackage

// ===== rtl/nrwm_cell.sv =====
// one rule slot of the table, with the token stage that passes through it
`timescale 1ns / 1ps

module nrwm_cell
  import nrwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic        valid_r;
  logic [1:0]  kind_r;
  logic [31:0] ip_r;
  logic [15:0] port_r;
  logic [31:0] tip_r;
  logic [15:0] tport_r;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic ins_hit;
  logic ins_append;
  logic lk_hit;

  always_comb begin
    ins_hit    = tok_i.vld && !tok_i.lookup && valid_r && (kind_r == tok_i.kind) &&
                 (ip_r == tok_i.ip) && (port_r == tok_i.port);
    // valid slots are contiguous, so the first empty one sees every rule first
    ins_append = tok_i.vld && !tok_i.lookup && !valid_r && !tok_i.found;

    lk_hit = 1'b0;
    if (tok_i.vld && tok_i.lookup && valid_r) begin
      case (kind_r)
        KIND_EXACT:         lk_hit = (ip_r == tok_i.ip) && (port_r == tok_i.port);
        KIND_ADDR_ANY_PORT: lk_hit = (ip_r == tok_i.ip);
        KIND_ANY_ADDR_PORT: lk_hit = (port_r == tok_i.port);
        default:            lk_hit = 1'b0;
      endcase
    end

    tok_nxt       = tok_i;
    tok_nxt.found = tok_i.found | ins_hit | ins_append;
    if (lk_hit && (kind_r < tok_i.best)) begin
      tok_nxt.best     = kind_r;
      tok_nxt.tgt_ip   = tip_r;
      tok_nxt.tgt_port = tport_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ins_append) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_append) begin
      kind_r <= tok_i.kind;
      ip_r   <= tok_i.ip;
      port_r <= tok_i.port;
    end
    if (ins_append || ins_hit) begin
      tip_r   <= tok_i.tgt_ip;
      tport_r <= tok_i.tgt_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ===== rtl/nat_rule_wildcard_match.sv =====
// Address-translation rule table with wildcard keys, built as a row of rule cells.
//
// A transaction is taken at a rising edge with start high and busy low. in_func
// selects insert (add or overwrite a rule) or lookup (translate a flow). in_key_kind,
// in_new_ip and in_new_port matter only for insert.
// The transaction travels down a row of TABLE_DEPTH cells, one cell per cycle; each
// cell holds one rule, compares it with the key and updates or forwards the result.
// The result shows on the out_ ports for exactly one cycle with out_valid high,
// registered after the token leaves the last cell. busy stays high from acceptance
// until the result appears, so one transaction is in flight at a time, and a new
// one can be taken at the edge that ends the result cycle.
// Lookups prefer an exact rule, then an address-with-any-port rule, then an
// any-address-with-port rule; out_match_kind 3 means no match or an insert.
// out_status is 1 when an insert of a new key finds every cell taken.
// Reset empties the table at once and drops any transaction in flight.
// The receiver cannot stall: a result is accepted in the cycle it is shown.
`timescale 1ns / 1ps

module nat_rule_wildcard_match
  import nrwm_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [31:0] in_key_ip,
  input  logic [15:0] in_key_port,
  input  logic [1:0]  in_key_kind,
  input  logic [31:0] in_new_ip,
  input  logic [15:0] in_new_port,
  output logic        out_valid,
  output logic [1:0]  out_match_kind,
  output logic [31:0] out_ip,
  output logic [15:0] out_port,
  output logic        out_status
);

  tok_t chain [TABLE_DEPTH+1];
  tok_t last;

  logic        busy_r, busy_nxt;
  logic        out_valid_r;
  logic [1:0]  out_match_kind_r;
  logic [31:0] out_ip_r;
  logic [15:0] out_port_r;
  logic        out_status_r;
  logic        accept;

  assign accept = start && !busy_r;

  // entry token: wildcard part of an insert key is cleared
  always_comb begin
    chain[0].vld    = accept;
    chain[0].lookup = (in_func == FUNC_LOOKUP);
    chain[0].kind   = in_key_kind;
    chain[0].ip     = in_key_ip;
    chain[0].port   = in_key_port;
    if (in_func == FUNC_INSERT) begin
      if (in_key_kind == KIND_ANY_ADDR_PORT) chain[0].ip = '0;
      if (in_key_kind == KIND_ADDR_ANY_PORT) chain[0].port = '0;
    end
    chain[0].tgt_ip   = (in_func == FUNC_LOOKUP) ? '0 : in_new_ip;
    chain[0].tgt_port = (in_func == FUNC_LOOKUP) ? '0 : in_new_port;
    chain[0].best     = KIND_NONE;
    // an insert with no valid kind is dropped silently
    chain[0].found    = (in_func == FUNC_INSERT) && (in_key_kind == KIND_NONE);
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    nrwm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign last = chain[TABLE_DEPTH];

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.vld) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= last.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (last.vld) begin
      out_match_kind_r <= last.lookup ? last.best : KIND_NONE;
      out_ip_r         <= last.lookup ? last.tgt_ip : '0;
      out_port_r       <= last.lookup ? last.tgt_port : '0;
      out_status_r     <= !last.lookup && !last.found;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_match_kind = out_match_kind_r;
  assign out_ip         = out_ip_r;
  assign out_port       = out_port_r;
  assign out_status     = out_status_r;

endmodule

// ===== rtl/nrwm_checker.sv =====
// port-level checks for the rule table, bound to the top level
`timescale 1ns / 1ps

module nrwm_checker
  import nrwm_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_match_kind,
  input logic [31:0] out_ip,
  input logic [15:0] out_port,
  input logic        out_status
);

  // a result strobe never comes back to back with another
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // an accepted transaction holds the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after acceptance");

  // the block is free again while its result is shown
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy during result cycle");

  // a refused insert reports no match
  a_full_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_match_kind == KIND_NONE))
    else $error("table-full status with a match kind");

  // no match gives a zero translation
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_match_kind == KIND_NONE)) |-> (out_ip == '0 && out_port == '0))
    else $error("non-zero translation without a match");

endmodule

bind nat_rule_wildcard_match nrwm_checker u_nrwm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_match_kind (out_match_kind),
  .out_ip         (out_ip),
  .out_port       (out_port),
  .out_status     (out_status)
);

// ===== tb/sv/tb.sv =====
// testbench for the wildcard translation rule table, self-checking against a behavioural table
`timescale 1ns / 1ps

module tb
  import nrwm_pkg::*;
();

  localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 12;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic        func;
    logic [31:0] ip;
    logic [15:0] port;
    logic [1:0]  kind;
    logic [31:0] new_ip;
    logic [15:0] new_port;
  } rule_op_t;

  typedef struct packed {
    logic [1:0]  match_kind;
    logic [31:0] ip;
    logic [15:0] port;
    logic        status;
  } xlat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_func = FUNC_INSERT;
  logic [31:0] in_key_ip = '0;
  logic [15:0] in_key_port = '0;
  logic [1:0]  in_key_kind = KIND_EXACT;
  logic [31:0] in_new_ip = '0;
  logic [15:0] in_new_port = '0;
  logic        out_valid;
  logic [1:0]  out_match_kind;
  logic [31:0] out_ip;
  logic [15:0] out_port;
  logic        out_status;

  // behavioural copy of the rule table
  logic [31:0] tbl_ip[DEPTH];
  logic [15:0] tbl_port[DEPTH];
  logic [1:0]  tbl_kind[DEPTH];
  logic [31:0] tbl_tgt_ip[DEPTH];
  logic [15:0] tbl_tgt_port[DEPTH];
  int          tbl_used = 0;

  xlat_t pending_xlat[$];
  int    n_errors = 0;
  int    n_sent = 0;
  int    n_inserts = 0;
  int    n_refused = 0;
  int    n_overwrites = 0;
  int    n_hits[4] = '{0, 0, 0, 0};
  int    burst_left = 0;
  int    cycle_count = 0;

  always #4 clk = ~clk;

  nat_rule_wildcard_match dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_key_ip      (in_key_ip),
    .in_key_port    (in_key_port),
    .in_key_kind    (in_key_kind),
    .in_new_ip      (in_new_ip),
    .in_new_port    (in_new_port),
    .out_valid      (out_valid),
    .out_match_kind (out_match_kind),
    .out_ip         (out_ip),
    .out_port       (out_port),
    .out_status     (out_status)
  );

  function automatic int find_entry(logic [1:0] kind, logic [31:0] ip, logic [15:0] port);
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_kind[i] == kind && tbl_ip[i] == ip && tbl_port[i] == port) return i;
    end
    return -1;
  endfunction

  // updates the table copy and returns the translation the block should give
  function automatic xlat_t predict_xlat(rule_op_t op);
    xlat_t       res;
    int          idx;
    logic [31:0] ip;
    logic [15:0] port;
    res = '{KIND_NONE, 32'd0, 16'd0, 1'b0};
    ip = op.ip;
    port = op.port;
    if (op.func == FUNC_INSERT) begin
      if (op.kind != KIND_NONE) begin
        n_inserts++;
        // the wildcard half of the key is dropped before comparing
        if (op.kind == KIND_ADDR_ANY_PORT) port = '0;
        else if (op.kind == KIND_ANY_ADDR_PORT) ip = '0;
        idx = find_entry(op.kind, ip, port);
        if (idx >= 0) n_overwrites++;
        if (idx < 0) begin
          if (tbl_used < DEPTH) begin
            idx = tbl_used;
            tbl_used++;
            tbl_ip[idx] = ip;
            tbl_port[idx] = port;
            tbl_kind[idx] = op.kind;
          end else begin
            res.status = 1'b1;
            n_refused++;
          end
        end
        if (idx >= 0) begin
          tbl_tgt_ip[idx] = op.new_ip;
          tbl_tgt_port[idx] = op.new_port;
        end
      end
    end else begin
      idx = find_entry(KIND_EXACT, ip, port);
      if (idx >= 0) begin
        res.match_kind = KIND_EXACT;
      end else begin
        idx = find_entry(KIND_ADDR_ANY_PORT, ip, 16'd0);
        if (idx >= 0) begin
          res.match_kind = KIND_ADDR_ANY_PORT;
        end else begin
          idx = find_entry(KIND_ANY_ADDR_PORT, 32'd0, port);
          if (idx >= 0) res.match_kind = KIND_ANY_ADDR_PORT;
        end
      end
      if (idx >= 0) begin
        res.ip = tbl_tgt_ip[idx];
        res.port = tbl_tgt_port[idx];
      end
      n_hits[res.match_kind]++;
    end
    return res;
  endfunction

  function automatic rule_op_t mk_op(logic func, logic [31:0] ip, logic [15:0] port,
                                     logic [1:0] kind, logic [31:0] nip, logic [15:0] nport);
    rule_op_t op;
    op = '{func, ip, port, kind, nip, nport};
    return op;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    n_errors++;
  endtask

  // sender runs in bursts of random length, with gaps of random length between most bursts
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 70);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_op(rule_op_t op);
    in_func <= op.func;
    in_key_ip <= op.ip;
    in_key_port <= op.port;
    in_key_kind <= op.kind;
    in_new_ip <= op.new_ip;
    in_new_port <= op.new_port;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_xlat.push_back(predict_xlat(op));
    n_sent++;
    pace_sender();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_fields();
    send_op(mk_op(FUNC_LOOKUP, 32'h0, 16'h0, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF, KIND_EXACT, 32'hFFFF_FFFF, 16'hFFFF));
    send_op(mk_op(FUNC_INSERT, 32'h0, 16'h0, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF));
    send_op(mk_op(FUNC_LOOKUP, 32'h0, 16'h0, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 16'h0, KIND_EXACT, 32'h0, 16'h0));
  endtask

  task automatic test_match_priority();
    logic [31:0] addr;
    logic [15:0] port;
    addr = 32'hC0A8_0001;
    port = 16'h1F90;
    // address rule: its port part is ignored
    send_op(mk_op(FUNC_INSERT, addr, 16'h1234, KIND_ADDR_ANY_PORT, 32'h0A00_0101, 16'h0050));
    send_op(mk_op(FUNC_LOOKUP, addr, 16'h5555, KIND_EXACT, 32'h0, 16'h0));
    // port rule: its address part is ignored
    send_op(mk_op(FUNC_INSERT, 32'h0A00_0001, port, KIND_ANY_ADDR_PORT, 32'h0A00_0202, 16'h0051));
    send_op(mk_op(FUNC_LOOKUP, 32'h0808_0808, port, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_LOOKUP, addr, port, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_INSERT, addr, port, KIND_EXACT, 32'h0A00_0303, 16'h0052));
    send_op(mk_op(FUNC_LOOKUP, addr, port, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_INSERT, addr, port, KIND_EXACT, 32'h5A5A_A5A5, 16'hA5A5));
    send_op(mk_op(FUNC_LOOKUP, addr, port, KIND_ADDR_ANY_PORT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_INSERT, addr, 16'hBEEF, KIND_ADDR_ANY_PORT, 32'h1234_5678, 16'h4321));
    send_op(mk_op(FUNC_LOOKUP, addr, 16'h0001, KIND_EXACT, 32'h0, 16'h0));
    // exact rule on port zero sits beside the address rule
    send_op(mk_op(FUNC_INSERT, addr, 16'h0, KIND_EXACT, 32'h0BAD_F00D, 16'h7777));
    send_op(mk_op(FUNC_LOOKUP, addr, 16'h0, KIND_EXACT, 32'h0, 16'h0));
    send_op(mk_op(FUNC_LOOKUP, 32'h0, port, KIND_EXACT, 32'h0, 16'h0));
  endtask

  task automatic test_ignored_kind();
    send_op(mk_op(FUNC_INSERT, 32'h7F00_0001, 16'h2222, KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF));
    send_op(mk_op(FUNC_LOOKUP, 32'h7F00_0001, 16'h2222, KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF));
  endtask

  // mostly keys from a small pool so that rules hit and the table fills up
  task automatic test_random_traffic(int count);
    rule_op_t    op;
    logic [31:0] addr_pool[POOL_SIZE];
    logic [15:0] port_pool[POOL_SIZE];
    for (int i = 0; i < POOL_SIZE; i++) begin
      addr_pool[i] = $urandom();
      port_pool[i] = 16'($urandom());
    end
    for (int i = 0; i < count; i++) begin
      op.func = ($urandom_range(0, 9) < 4) ? FUNC_INSERT : FUNC_LOOKUP;
      op.kind = ($urandom_range(0, 24) == 0) ? KIND_NONE : 2'($urandom_range(0, 2));
      op.new_ip = $urandom();
      op.new_port = 16'($urandom());
      if ($urandom_range(0, 7) == 0) begin
        op.ip = $urandom();
        op.port = 16'($urandom());
      end else begin
        op.ip = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        op.port = port_pool[$urandom_range(0, POOL_SIZE - 1)];
      end
      send_op(op);
      if (i == count / 2) wait_drained();
    end
  endtask

  always @(posedge clk) begin : check_results
    xlat_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (pending_xlat.size() == 0) begin
        report_mismatch("unexpected result", {31'd0, out_valid}, 32'd0);
      end else begin
        want = pending_xlat.pop_front();
        if (out_match_kind !== want.match_kind)
          report_mismatch("match kind", 32'(out_match_kind), 32'(want.match_kind));
        if (out_ip !== want.ip) report_mismatch("address", out_ip, want.ip);
        if (out_port !== want.port) report_mismatch("port", 32'(out_port), 32'(want.port));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_xlat.size());
      $display("** nat_rule_wildcard_match: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_fields();
    test_match_priority();
    test_ignored_kind();
    test_random_traffic(630);
    wait_drained();
    repeat (DEPTH + 4) @(posedge clk);
    $display("%0d transactions: %0d inserts (%0d overwrites, %0d refused, table %0d/%0d)",
             n_sent, n_inserts, n_overwrites, n_refused, tbl_used, DEPTH);
    $display("lookups exact %0d, address %0d, port %0d, miss %0d; %0d mismatches",
             n_hits[KIND_EXACT], n_hits[KIND_ADDR_ANY_PORT], n_hits[KIND_ANY_ADDR_PORT],
             n_hits[KIND_NONE], n_errors);
    if (n_errors == 0 && pending_xlat.size() == 0) begin
      $display("** nat_rule_wildcard_match: PASSED **");
    end else begin
      $display("** nat_rule_wildcard_match: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nrwm_pkg.sv
rtl/nrwm_cell.sv
rtl/nat_rule_wildcard_match.sv
rtl/nrwm_checker.sv
tb/sv/tb.sv
